// ===== rtl/core/rarv_pkg.sv =====
// Package for the raw audio resample and volume block.
// Holds widths, phase constants, register indexes, payload structs and the
// sequencer control word; no dependencies.
package rarv_pkg;

   // Phase arithmetic: the phase step is a fixed point value with
   // PHASE_FRAC_BITS fraction bits, saturated to [ONE/16, ONE*16].
   localparam int PHASE_FRAC_BITS = 16;
   localparam int PHASE_STEP_W    = PHASE_FRAC_BITS + 5;
   localparam int PHASE_W         = PHASE_FRAC_BITS + 6;

   localparam logic [PHASE_W-1:0] ONE_PHASE = PHASE_W'(1) << PHASE_FRAC_BITS;

   localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_MIN =
      PHASE_STEP_W'(1) << (PHASE_FRAC_BITS - 4);
   localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_MAX =
      PHASE_STEP_W'(1) << (PHASE_FRAC_BITS + 4);
   localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RESET =
      PHASE_STEP_W'(1) << PHASE_FRAC_BITS;

   // The accumulator never reaches one phase unit past the largest step.
   localparam logic [PHASE_W-1:0] PHASE_LIMIT = ONE_PHASE + PHASE_W'(PHASE_STEP_MAX);

   // Ring buffer addressing (depth is a power of two).
   localparam int RING_DEPTH   = 8192;
   localparam int RING_BITS    = $clog2(RING_DEPTH);
   localparam int RING_INDEX_W = 13;
   localparam int POS_W        = 31;

   // Gain is Q1.16 with unity at 65536.
   localparam int              GAIN_W     = 17;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'd65536;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd45875;

   localparam int SAMPLE_W = 16;
   localparam int VALUE_W  = 24;
   localparam int PROD_W   = SAMPLE_W + GAIN_W;

   // Configuration port.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE = 4'd0,
      CSR_FORMAT = 4'd1,
      CSR_STEP   = 4'd2,
      CSR_GAIN   = 4'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FMT_S16_STEREO = 2'd0,
      FMT_S16_MONO   = 2'd1,
      FMT_S8_STEREO  = 2'd2,
      FMT_U8_MONO    = 2'd3
   } fmt_type;

   typedef struct packed {
      logic [15:0]      raw_left;
      logic [15:0]      raw_right;
      logic [POS_W-1:0] play_time;
      logic             batch_end;
   } req_payload_type;

   typedef struct packed {
      logic [RING_INDEX_W-1:0]   ring_index;
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;
      logic                      last_of_run;
   } rsp_payload_type;

   // Sequencer program counter values.
   typedef enum logic [2:0] {
      SEQ_ACCEPT = 3'd0,
      SEQ_PREP   = 3'd1,
      SEQ_MUL_R  = 3'd2,
      SEQ_FIN_R  = 3'd3,
      SEQ_EMIT   = 3'd4,
      SEQ_FINISH = 3'd5,
      SEQ_CLOSE  = 3'd6
   } seq_step_type;

   // Jump conditions: the jump to target is taken when the condition holds,
   // otherwise the program counter advances by one.
   typedef enum logic [2:0] {
      COND_NEXT      = 3'd0,
      COND_ALWAYS    = 3'd1,
      COND_WAIT_REQ  = 3'd2,
      COND_DISABLED  = 3'd3,
      COND_EMIT_MORE = 3'd4
   } cond_type;

   typedef struct packed {
      logic         accept;
      logic         open_batch;
      logic         mul_left;
      logic         mul_right;
      logic         fin_left;
      logic         fin_right;
      logic         emit;
      logic         finish;
      logic         close;
      cond_type     cond;
      seq_step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_valid;
      logic disabled;
      logic emit_done;
   } seq_flags_type;

endpackage

// ===== rtl/core/raw_audio_resample_volume.sv =====
// Top level of the raw audio resample and volume block.
// Depends on rarv_pkg and rarv_sequencer.
//
// Usage:
// Each req transaction carries one source audio frame (raw_left, raw_right,
// play_time, batch_end). The block resamples by nearest neighbor into a
// stereo ring buffer: every rsp transaction is one ring write with its slot
// index, the scaled left and right values, and last_of_run set on the final
// write caused by the frame. A frame causes zero to sixteen writes.
// The csr channel writes enable, sample_format, phase_step and volume_gain by
// index; it is always ready, and writes belong in idle periods only.
// Operation: a short microcoded program handles one frame at a time and takes
// no new req until it is done. The prepare, right multiply and right finish
// steps follow the req transaction, then the emit step loads the first write
// into the rsp register; the writes then follow one per cycle while the rsp
// register is free. A disabled frame goes from prepare to close. A shared
// 16x17 multiplier serves each channel once; the rsp register is single.
// Reset clears the configuration to its defaults, the write position, the
// phase accumulator and the batch flag. A receiver stall holds the pending
// write in the rsp register; with writes left, the sequencer stays in emit.
module raw_audio_resample_volume
   import rarv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_data,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef struct packed {
      logic                neg;
      logic [SAMPLE_W-1:0] mag;
   } sample_type;

   // Configuration registers.
   logic                    enable_ff,     enable_in;
   fmt_type                 format_ff,     format_in;
   logic [PHASE_STEP_W-1:0] phase_step_ff, phase_step_in;
   logic [GAIN_W-1:0]       gain_ff,       gain_in;

   // Resampler state.
   logic [POS_W-1:0]   write_position_ff, write_position_in;
   logic [PHASE_W-1:0] phase_accum_ff,    phase_accum_in;
   logic               batch_open_ff,     batch_open_in;

   // Datapath registers.
   req_payload_type           frame_ff;
   logic [PROD_W-1:0]         product_ff, product_in;
   logic                      prod_neg_ff, prod_neg_in;
   logic signed [VALUE_W-1:0] value_left_ff, value_right_ff, scaled;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff,  rsp_data_in;

   ctrl_word_type ctrl;
   seq_flags_type flags;

   sample_type          sample_left, sample_right, mul_sample;
   logic                mono, eight_bit;
   logic [GAIN_W-1:0]   quotient;
   logic signed [17:0]  quotient_s;
   logic [PHASE_W-1:0]  phase_sum;
   logic                phase_below_one, last_write, rsp_free, emit_fire;
   logic [POS_W-1:0]    ring_slot;

   // Turns a raw sample into sign and magnitude for the given format.
   function automatic sample_type decode_sample(input logic [SAMPLE_W-1:0] raw,
                                                input fmt_type fmt);
      sample_type s;
      case (fmt)
         FMT_S16_STEREO, FMT_S16_MONO: begin
            s.neg = raw[15];
            s.mag = raw[15] ? SAMPLE_W'(-raw) : raw;
         end
         FMT_S8_STEREO: begin
            s.neg = raw[7];
            s.mag = {8'd0, (raw[7] ? 8'(-raw[7:0]) : raw[7:0])};
         end
         default: begin
            // Unsigned 8-bit is centered on 128.
            s.neg = !raw[7];
            s.mag = {8'd0, (raw[7] ? {1'b0, raw[6:0]} : 8'(8'd128 - raw[7:0]))};
         end
      endcase
      return s;
   endfunction

   rarv_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // ---------------------------------------------------------------------
   // Configuration writes with saturation.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      enable_in     = enable_ff;
      format_in     = format_ff;
      phase_step_in = phase_step_ff;
      gain_in       = gain_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE: enable_in = csr_wdata[0];
            CSR_FORMAT: format_in = fmt_type'(csr_wdata[1:0]);
            CSR_STEP: begin
               if (csr_wdata < CSR_DATA_W'(PHASE_STEP_MIN)) begin
                  phase_step_in = PHASE_STEP_MIN;
               end else if (csr_wdata > CSR_DATA_W'(PHASE_STEP_MAX)) begin
                  phase_step_in = PHASE_STEP_MAX;
               end else begin
                  phase_step_in = csr_wdata[PHASE_STEP_W-1:0];
               end
            end
            CSR_GAIN: begin
               gain_in = (csr_wdata > CSR_DATA_W'(GAIN_UNITY)) ? GAIN_UNITY
                                                               : csr_wdata[GAIN_W-1:0];
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Sample decode, shared multiplier and scaling.
   // ---------------------------------------------------------------------
   assign mono      = (format_ff inside {FMT_S16_MONO, FMT_U8_MONO});
   assign eight_bit = (format_ff inside {FMT_S8_STEREO, FMT_U8_MONO});

   assign sample_left  = decode_sample(frame_ff.raw_left, format_ff);
   assign sample_right = decode_sample(mono ? frame_ff.raw_left : frame_ff.raw_right,
                                       format_ff);
   assign mul_sample   = ctrl.mul_right ? sample_right : sample_left;

   assign product_in  = PROD_W'(mul_sample.mag) * PROD_W'(gain_ff);
   assign prod_neg_in = mul_sample.neg;

   // Truncation toward zero: scale the magnitude, then restore the sign.
   assign quotient   = product_ff[PROD_W-1:16];
   assign quotient_s = prod_neg_ff ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
   assign scaled     = eight_bit ? {quotient_s[7:0], 16'd0} : {quotient_s[15:0], 8'd0};

   // ---------------------------------------------------------------------
   // Emit loop: one ring write per cycle while the phase is below one and rsp is free.
   // ---------------------------------------------------------------------
   assign phase_below_one = (phase_accum_ff < ONE_PHASE);
   assign phase_sum       = phase_accum_ff + PHASE_W'(phase_step_ff);
   assign last_write      = (phase_sum >= ONE_PHASE);
   assign rsp_free        = !rsp_valid_ff || rsp_ready;
   assign emit_fire       = ctrl.emit && rsp_free && phase_below_one;
   assign ring_slot       = write_position_ff & ((POS_W'(1) << RING_BITS) - POS_W'(1));

   assign flags.req_valid = req_valid;
   assign flags.disabled  = !enable_ff;
   assign flags.emit_done = !phase_below_one || (emit_fire && last_write);

   always_comb begin
      write_position_in = write_position_ff;
      phase_accum_in    = phase_accum_ff;
      batch_open_in     = batch_open_ff;

      // First frame of a batch: catch up with the play time, restart phase.
      if (ctrl.open_batch && enable_ff && !batch_open_ff) begin
         if (write_position_ff < frame_ff.play_time) begin
            write_position_in = frame_ff.play_time;
         end
         phase_accum_in = '0;
         batch_open_in  = 1'b1;
      end

      if (emit_fire) begin
         write_position_in = write_position_ff + POS_W'(1);
         phase_accum_in    = phase_sum;
      end

      // Carry the leftover phase into the next frame.
      if (ctrl.finish) begin
         phase_accum_in = phase_below_one ? '0 : phase_accum_ff - ONE_PHASE;
      end

      if (ctrl.close && frame_ff.batch_end) begin
         batch_open_in  = 1'b0;
         phase_accum_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (emit_fire) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.ring_index  = ring_slot[RING_INDEX_W-1:0];
         rsp_data_in.left_value  = value_left_ff;
         rsp_data_in.right_value = value_right_ff;
         rsp_data_in.last_of_run = last_write;
      end
   end

   assign req_ready = ctrl.accept;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= 1'b0;
         format_ff         <= FMT_S16_STEREO;
         phase_step_ff     <= PHASE_STEP_RESET;
         gain_ff           <= GAIN_RESET;
         write_position_ff <= '0;
         phase_accum_ff    <= '0;
         batch_open_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         enable_ff         <= enable_in;
         format_ff         <= format_in;
         phase_step_ff     <= phase_step_in;
         gain_ff           <= gain_in;
         write_position_ff <= write_position_in;
         phase_accum_ff    <= phase_accum_in;
         batch_open_ff     <= batch_open_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         frame_ff <= req_data;
      end
      if (ctrl.mul_left || ctrl.mul_right) begin
         product_ff  <= product_in;
         prod_neg_ff <= prod_neg_in;
      end
      if (ctrl.fin_left) begin
         value_left_ff <= scaled;
      end
      if (ctrl.fin_right) begin
         value_right_ff <= scaled;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   a_emit_needs_enable: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> enable_ff)
      else $error("ring write issued while disabled");

   a_open_sets_batch: assert property (@(posedge clock) disable iff (reset)
      (ctrl.open_batch && enable_ff) |=> batch_open_ff)
      else $error("batch not open after first frame");

   a_last_leaves_emit: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && last_write) |=> !ctrl.emit)
      else $error("sequencer stayed in emit after last write");

   a_position_steps: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (write_position_ff == $past(write_position_ff) + POS_W'(1)))
      else $error("write position did not advance by one");

   a_phase_bounded: assert property (@(posedge clock) disable iff (reset)
      phase_accum_ff < PHASE_LIMIT)
      else $error("phase accumulator out of range");

endmodule

// ===== rtl/core/rarv_sequencer.sv =====
// Microcode sequencer for the raw audio resample and volume block.
// Holds the program counter and the control store; uses rarv_pkg.
module rarv_sequencer
   import rarv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  seq_flags_type flags,
   output ctrl_word_type ctrl
);

   seq_step_type pc_ff;
   seq_step_type pc_in;
   logic         taken;

   // Control store, one word per program step.
   function automatic ctrl_word_type ucode(input seq_step_type step);
      ctrl_word_type w;
      w        = '0;
      w.cond   = COND_NEXT;
      w.target = SEQ_ACCEPT;
      case (step)
         SEQ_ACCEPT: begin
            w.accept = 1'b1;
            w.cond   = COND_WAIT_REQ;
            w.target = SEQ_ACCEPT;
         end
         SEQ_PREP: begin
            w.open_batch = 1'b1;
            w.mul_left   = 1'b1;
            w.cond       = COND_DISABLED;
            w.target     = SEQ_CLOSE;
         end
         SEQ_MUL_R: begin
            w.fin_left  = 1'b1;
            w.mul_right = 1'b1;
         end
         SEQ_FIN_R: begin
            w.fin_right = 1'b1;
         end
         SEQ_EMIT: begin
            w.emit   = 1'b1;
            w.cond   = COND_EMIT_MORE;
            w.target = SEQ_EMIT;
         end
         SEQ_FINISH: begin
            w.finish = 1'b1;
            w.close  = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = SEQ_ACCEPT;
         end
         SEQ_CLOSE: begin
            w.close  = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = SEQ_ACCEPT;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = SEQ_ACCEPT;
         end
      endcase
      return w;
   endfunction

   assign ctrl = ucode(pc_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NEXT:      taken = 1'b0;
         COND_ALWAYS:    taken = 1'b1;
         COND_WAIT_REQ:  taken = !flags.req_valid;
         COND_DISABLED:  taken = flags.disabled;
         COND_EMIT_MORE: taken = !flags.emit_done;
         default:        taken = 1'b1;
      endcase
      pc_in = taken ? ctrl.target : seq_step_type'(pc_ff + 3'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= SEQ_ACCEPT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
